// ===== hdl/rv32im_executor_with_crc_signature_unit_macros.svh =====
// assertion macros for the rv32im executor block
// expects signals clk and rst_n in the scope of each use
`ifndef RV32IM_EXECUTOR_WITH_CRC_SIGNATURE_UNIT_MACROS_SVH
`define RV32IM_EXECUTOR_WITH_CRC_SIGNATURE_UNIT_MACROS_SVH
`ifndef SYNTH
`define RVX_ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rvx assertion failed");
`define RVX_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("rvx assertion failed");
`else
`define RVX_ASSERT_IMPLIES(label, a, b)
`define RVX_ASSERT_NEXT(label, a, b)
`endif
`endif

// ===== hdl/rvx_pkg.sv =====
// shared types and constants of the rv32im executor
// no dependencies
`timescale 1ns / 1ps
package rvx_pkg;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_EXECUTED = 3'd1,
    ST_HALTED   = 3'd2,
    ST_TRAPPED  = 3'd3,
    ST_STOPPED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    K_SIMPLE = 3'd0,
    K_MUL    = 3'd1,
    K_DIV    = 3'd2,
    K_LOAD   = 3'd3,
    K_STORE  = 3'd4,
    K_TRAP   = 3'd5
  } kind_t;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic    accept;
    logic    set_trap;
    logic    clr;
    logic    ld_wr;
    logic    st_wr;
    logic    mem_rd;
    logic    rd_fetch;
    logic    rf_sel2;
    logic    cap_ir;
    logic    cap_a;
    logic    cap_b;
    logic    exec;
    logic    mul_start;
    logic    mul_fix;
    logic    div_init;
    logic    div_step;
    logic    div_fix;
    logic    ld_fix;
    logic    commit;
    logic    crc_step;
    logic    out_load;
    status_t out_status;
    logic [4:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       trap;
    logic       pc_ok;
    logic       ebreak;
    kind_t      kind;
    logic       reg_nz;
    logic [1:0] len_m1;
    logic       out_free;
  } stat_t;

endpackage

// ===== hdl/rvx_in_if.sv =====
// input channel: command, load address and load word
// no dependencies
`timescale 1ns / 1ps
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] load_address;
  logic [31:0] load_word;
  modport source (output valid, command, load_address, load_word, input ready);
  modport sink (input valid, command, load_address, load_word, output ready);
endinterface

// ===== hdl/rvx_out_if.sv =====
// result channel: status, pc, register write and signature
// no dependencies
`timescale 1ns / 1ps
interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] program_counter;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [31:0] signature;
  modport source (output valid, status, program_counter, reg_written, reg_index,
                  reg_value, signature, input ready);
  modport sink (input valid, status, program_counter, reg_written, reg_index,
                reg_value, signature, output ready);
endinterface

// ===== hdl/rvx_ctrl.sv =====
// sequencing state machine of the executor
// depends on rvx_pkg
`timescale 1ns / 1ps
module rvx_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_command,
  output logic           in_ready,
  input  rvx_pkg::stat_t stat,
  output rvx_pkg::cmd_t  cmd
);
  import rvx_pkg::*;

  typedef enum logic [19:0] {
    S_CLEAR  = 20'h00001,
    S_IDLE   = 20'h00002,
    S_LOADW  = 20'h00004,
    S_FETCH  = 20'h00008,
    S_FWAIT  = 20'h00010,
    S_RS1    = 20'h00020,
    S_RS2    = 20'h00040,
    S_OPS    = 20'h00080,
    S_EXEC   = 20'h00100,
    S_MUL    = 20'h00200,
    S_MULC   = 20'h00400,
    S_DIV    = 20'h00800,
    S_DIVC   = 20'h01000,
    S_LDRD   = 20'h02000,
    S_LDWAIT = 20'h04000,
    S_LDFIX  = 20'h08000,
    S_STWR   = 20'h10000,
    S_WB     = 20'h20000,
    S_CRC    = 20'h40000,
    S_FIN    = 20'h80000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  status_t    fin_r, fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      fin_r   <= ST_LOADED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.cnt   = cnt_r;
    in_ready  = 1'b0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!in_command) begin
            state_nxt = S_LOADW;
          end else if (stat.trap) begin
            fin_nxt   = ST_STOPPED;
            state_nxt = S_FIN;
          end else if (!stat.pc_ok) begin
            cmd.set_trap = 1'b1;
            fin_nxt      = ST_TRAPPED;
            state_nxt    = S_FIN;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_LOADW: begin
        cmd.ld_wr = 1'b1;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r[1:0] == 2'd3) begin
          fin_nxt   = ST_LOADED;
          state_nxt = S_FIN;
        end
      end
      S_FETCH: begin
        cmd.mem_rd   = 1'b1;
        cmd.rd_fetch = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = S_FWAIT;
      end
      S_FWAIT: state_nxt = S_RS1;
      S_RS1: begin
        cmd.cap_ir = 1'b1;
        if (stat.ebreak) begin
          fin_nxt   = ST_HALTED;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RS2;
        end
      end
      S_RS2: begin
        cmd.rf_sel2 = 1'b1;
        cmd.cap_a   = 1'b1;
        state_nxt   = S_OPS;
      end
      S_OPS: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_nxt  = '0;
        unique case (stat.kind)
          K_MUL:   state_nxt = S_MUL;
          K_DIV: begin
            cmd.div_init = 1'b1;
            state_nxt    = S_DIV;
          end
          K_LOAD:  state_nxt = S_LDRD;
          K_STORE: state_nxt = S_STWR;
          K_SIMPLE: state_nxt = S_WB;
          default: begin
            cmd.set_trap = 1'b1;
            fin_nxt      = ST_TRAPPED;
            state_nxt    = S_FIN;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MULC;
      end
      S_MULC: begin
        cmd.mul_fix = 1'b1;
        state_nxt   = S_WB;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_DIVC;
      end
      S_DIVC: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_WB;
      end
      S_LDRD: begin
        cmd.mem_rd = 1'b1;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r[1:0] == stat.len_m1) state_nxt = S_LDWAIT;
      end
      S_LDWAIT: state_nxt = S_LDFIX;
      S_LDFIX: begin
        cmd.ld_fix = 1'b1;
        state_nxt  = S_WB;
      end
      S_STWR: begin
        cmd.st_wr = 1'b1;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r[1:0] == stat.len_m1) state_nxt = S_WB;
      end
      S_WB: begin
        cmd.commit = 1'b1;
        cnt_nxt    = '0;
        fin_nxt    = ST_EXECUTED;
        state_nxt  = stat.reg_nz ? S_CRC : S_FIN;
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd4) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = fin_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== hdl/rvx_datapath.sv =====
// architectural state, memories, alu, multiply, divide, crc and result register
// depends on rvx_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rv32im_executor_with_crc_signature_unit_macros.svh"
module rvx_datapath #(
  parameter int MEM_BYTES = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rvx_pkg::cmd_t  cmd,
  output rvx_pkg::stat_t stat,
  input  logic [15:0]    in_load_address,
  input  logic [31:0]    in_load_word,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [2:0]     out_status,
  output logic [31:0]    out_program_counter,
  output logic           out_reg_written,
  output logic [4:0]     out_reg_index,
  output logic [31:0]    out_reg_value,
  output logic [31:0]    out_signature
);
  import rvx_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

  logic [7:0]  byte_mem [MEM_BYTES];
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;

  logic [AW-1:0] clr_r;
  logic          clr_done_r;
  logic [31:0]   pc_r, crc_r, ir_r, rbuf_r, a_r, b_r, res_r, next_r, addr_r;
  logic          trap_r, ow_r, rd_vld_r, rf_qv_r, out_valid_r;
  logic [1:0]    rd_idx_r;
  logic [7:0]    mem_q_r;
  logic [31:0]   rf_q_r;
  logic [15:0]   ld_base_r;
  logic [31:0]   ld_word_r;
  logic [63:0]   prod_r;
  logic [31:0]   quo_r, rem_r, mb_r;
  logic [2:0]    o_status_r;
  logic [31:0]   o_pc_r, o_value_r, o_sig_r;
  logic          o_written_r;
  logic [4:0]    o_index_r;

  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [31:0] cnt32, acc_addr, simple_res, next_pc;
  logic [1:0]  len_m1;
  logic        acc_ok, take, writes, sgn, an, bn;
  kind_t       kind;
  logic [31:0] ra32, wa32, ld_wa;
  logic [7:0]  wd;
  logic        we, ld_ok;
  logic [4:0]  rf_ra;
  logic [32:0] rem_sh;
  logic [31:0] hu, div_res, mul_res, ld_res;

  function automatic logic [31:0] alu_f(input logic [2:0] f, input logic alt,
                                        input logic [31:0] x, input logic [31:0] y);
    logic [31:0] r;
    case (f)
      3'd0: r = alt ? x - y : x + y;
      3'd1: r = x << y[4:0];
      3'd2: r = {31'b0, $signed(x) < $signed(y)};
      3'd3: r = {31'b0, x < y};
      3'd4: r = x ^ y;
      3'd5: r = alt ? 32'($signed(x) >>> y[4:0]) : x >> y[4:0];
      3'd6: r = x | y;
      default: r = x & y;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] x;
    x = c ^ {24'b0, d};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  assign op    = ir_r[6:0];
  assign rd    = ir_r[11:7];
  assign f3    = ir_r[14:12];
  assign f7    = ir_r[31:25];
  assign imm_i = {{20{ir_r[31]}}, ir_r[31:20]};
  assign imm_s = {{20{ir_r[31]}}, ir_r[31:25], ir_r[11:7]};
  assign imm_b = {{20{ir_r[31]}}, ir_r[7], ir_r[30:25], ir_r[11:8], 1'b0};
  assign imm_j = {{12{ir_r[31]}}, ir_r[19:12], ir_r[20], ir_r[30:21], 1'b0};
  assign imm_u = {ir_r[31:12], 12'b0};
  assign cnt32 = {30'b0, cmd.cnt[1:0]};

  // access size and bounds
  always_comb begin
    if (op == OP_STORE) begin
      len_m1   = (f3 == 3'd0) ? 2'd0 : ((f3 == 3'd1) ? 2'd1 : 2'd3);
      acc_addr = a_r + imm_s;
    end else begin
      len_m1   = (f3[1:0] == 2'd0) ? 2'd0 : ((f3[1:0] == 2'd1) ? 2'd1 : 2'd3);
      acc_addr = a_r + imm_i;
    end
  end
  assign acc_ok = ({1'b0, acc_addr} + 33'(len_m1) + 33'd1) <= MEM_LIM;

  always_comb begin
    case (f3)
      3'd0: take = a_r == b_r;
      3'd1: take = a_r != b_r;
      3'd4: take = $signed(a_r) < $signed(b_r);
      3'd5: take = !($signed(a_r) < $signed(b_r));
      3'd6: take = a_r < b_r;
      3'd7: take = a_r >= b_r;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    kind       = K_TRAP;
    writes     = 1'b1;
    simple_res = pc_r + 32'd4;
    next_pc    = pc_r + 32'd4;
    unique case (op)
      OP_REG: begin
        simple_res = alu_f(f3, f7 == F7_ALT, a_r, b_r);
        kind       = (f7 == F7_MULDIV) ? (f3[2] ? K_DIV : K_MUL) : K_SIMPLE;
      end
      OP_IMM: begin
        simple_res = alu_f(f3, (f3 == 3'd5) && (f7 == F7_ALT), a_r, imm_i);
        kind       = K_SIMPLE;
      end
      OP_LUI: begin
        simple_res = imm_u;
        kind       = K_SIMPLE;
      end
      OP_AUIPC: begin
        simple_res = pc_r + imm_u;
        kind       = K_SIMPLE;
      end
      OP_JAL: begin
        next_pc = pc_r + imm_j;
        kind    = K_SIMPLE;
      end
      OP_JALR: begin
        next_pc = (a_r + imm_i) & ~32'd1;
        kind    = K_SIMPLE;
      end
      OP_BRANCH: begin
        writes = 1'b0;
        if (take) next_pc = pc_r + imm_b;
        kind = K_SIMPLE;
      end
      OP_LOAD: begin
        kind = (f3 == 3'd3 || f3 > 3'd5 || !acc_ok) ? K_TRAP : K_LOAD;
      end
      OP_STORE: begin
        writes = 1'b0;
        kind   = (f3 > 3'd2 || !acc_ok) ? K_TRAP : K_STORE;
      end
      default: kind = K_TRAP;
    endcase
  end

  // byte memory ports
  assign ra32  = cmd.rd_fetch ? pc_r + cnt32 : addr_r + cnt32;
  assign ld_wa = {16'b0, ld_base_r} + cnt32;
  assign ld_ok = {1'b0, ld_wa} < MEM_LIM;
  always_comb begin
    we   = 1'b0;
    wa32 = ld_wa;
    wd   = ld_word_r[8*cmd.cnt[1:0] +: 8];
    if (cmd.clr) begin
      we   = 1'b1;
      wa32 = 32'(clr_r);
      wd   = 8'd0;
    end else if (cmd.ld_wr) begin
      we = ld_ok;
    end else if (cmd.st_wr) begin
      we   = 1'b1;
      wa32 = addr_r + cnt32;
      wd   = b_r[8*cmd.cnt[1:0] +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (we) byte_mem[wa32[AW-1:0]] <= wd;
    if (cmd.mem_rd) mem_q_r <= byte_mem[ra32[AW-1:0]];
  end

  // register file
  assign rf_ra = cmd.rf_sel2 ? ir_r[24:20] : rbuf_r[19:15];
  always_ff @(posedge clk) begin
    rf_q_r <= rf_mem[rf_ra];
    if (cmd.commit && writes && rd != 5'd0) rf_mem[rd] <= res_r;
  end

  // multiply and divide finishing
  assign sgn = !f3[0];
  assign an  = sgn && a_r[31];
  assign bn  = sgn && b_r[31];
  assign hu  = prod_r[63:32];
  always_comb begin
    case (f3[1:0])
      2'd0: mul_res = prod_r[31:0];
      2'd1: mul_res = hu - (a_r[31] ? b_r : 32'd0) - (b_r[31] ? a_r : 32'd0);
      2'd2: mul_res = hu - (a_r[31] ? b_r : 32'd0);
      default: mul_res = hu;
    endcase
  end
  always_comb begin
    if (b_r == 32'd0) begin
      div_res = f3[1] ? a_r : 32'hFFFF_FFFF;
    end else if (!f3[1]) begin
      div_res = (an != bn) ? 32'd0 - quo_r : quo_r;
    end else begin
      div_res = an ? 32'd0 - rem_r : rem_r;
    end
  end
  assign rem_sh = {rem_r, quo_r[31]};

  always_comb begin
    case (f3)
      3'd0: ld_res = {{24{rbuf_r[7]}}, rbuf_r[7:0]};
      3'd1: ld_res = {{16{rbuf_r[15]}}, rbuf_r[15:0]};
      3'd4: ld_res = {24'b0, rbuf_r[7:0]};
      3'd5: ld_res = {16'b0, rbuf_r[15:0]};
      default: ld_res = rbuf_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      clr_done_r  <= 1'b0;
      pc_r        <= '0;
      crc_r       <= CRC_INIT;
      trap_r      <= 1'b0;
      rf_vld_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ow_r        <= 1'b0;
    end else begin
      if (cmd.clr) begin
        if (clr_r == AW'(MEM_BYTES - 1)) clr_done_r <= 1'b1;
        else clr_r <= clr_r + 1'b1;
      end
      if (cmd.set_trap) trap_r <= 1'b1;
      rd_vld_r <= cmd.mem_rd;
      if (cmd.commit) begin
        pc_r <= next_r;
        ow_r <= writes && rd != 5'd0;
        if (writes && rd != 5'd0) rf_vld_r[rd] <= 1'b1;
      end
      if (cmd.crc_step) begin
        crc_r <= crc8(crc_r, (cmd.cnt == 5'd4) ? {3'b0, rd} : res_r[8*cmd.cnt[1:0] +: 8]);
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rf_qv_r  <= rf_vld_r[rf_ra];
    rd_idx_r <= cmd.cnt[1:0];
    if (rd_vld_r) rbuf_r[8*rd_idx_r +: 8] <= mem_q_r;
    if (cmd.accept) begin
      ld_base_r <= {in_load_address[15:2], 2'b00};
      ld_word_r <= in_load_word;
    end
    if (cmd.cap_ir) ir_r <= rbuf_r;
    if (cmd.cap_a) a_r <= rf_qv_r ? rf_q_r : 32'd0;
    if (cmd.cap_b) b_r <= rf_qv_r ? rf_q_r : 32'd0;
    if (cmd.exec) begin
      res_r  <= simple_res;
      next_r <= next_pc;
      addr_r <= acc_addr;
    end
    if (cmd.mul_start) prod_r <= a_r * b_r;
    if (cmd.mul_fix) res_r <= mul_res;
    if (cmd.div_init) begin
      quo_r <= an ? 32'd0 - a_r : a_r;
      mb_r  <= bn ? 32'd0 - b_r : b_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, mb_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, mb_r});
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
    if (cmd.div_fix) res_r <= div_res;
    if (cmd.ld_fix) res_r <= ld_res;
    if (cmd.out_load) begin
      o_status_r <= cmd.out_status;
      o_pc_r     <= pc_r;
      o_sig_r    <= ~crc_r;
      if (cmd.out_status == ST_EXECUTED && ow_r) begin
        o_written_r <= 1'b1;
        o_index_r   <= rd;
        o_value_r   <= res_r;
      end else begin
        o_written_r <= 1'b0;
        o_index_r   <= '0;
        o_value_r   <= '0;
      end
    end
  end

  assign stat.clr_done = clr_done_r;
  assign stat.trap     = trap_r;
  assign stat.pc_ok    = ({1'b0, pc_r} + 33'd4) <= MEM_LIM;
  assign stat.ebreak   = rbuf_r == EBREAK_WORD;
  assign stat.kind     = kind;
  assign stat.reg_nz   = writes && rd != 5'd0;
  assign stat.len_m1   = len_m1;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_program_counter = o_pc_r;
  assign out_reg_written     = o_written_r;
  assign out_reg_index       = o_index_r;
  assign out_reg_value       = o_value_r;
  assign out_signature       = o_sig_r;

  `RVX_ASSERT_NEXT(a_trap_sticky, trap_r, trap_r)
  `RVX_ASSERT_IMPLIES(a_out_free, cmd.out_load, !out_valid_r || out_ready)
  `RVX_ASSERT_IMPLIES(a_commit_after_clear, cmd.commit || cmd.accept, clr_done_r)

endmodule

// ===== hdl/rv32im_executor_with_crc_signature_unit.sv =====
// rv32im executor with crc-32 signature of register writes
// top level: ties the controller and datapath to the two channels
// depends on rvx_pkg, rvx_in_if, rvx_out_if, rvx_ctrl, rvx_datapath
//
// in_chan carries one transaction per command: command 0 writes load_word
// little-endian at load_address (low two bits dropped), command 1 runs the
// instruction at the pc. out_chan returns exactly one transaction for each.
// after reset the byte memory is swept to zero, one byte a cycle; in_chan.ready
// stays low during the sweep. registers, pc and trap clear at once and the crc
// starts at all ones. a load command writes its bytes through the byte-wide
// memory port. an execute goes straight to its result when stopped or the pc
// is out of range; otherwise it makes 4 fetch reads and halts at ebreak, or
// else reads the registers and then traps on a decode fault or makes up to 4
// data byte accesses and, when a register is written, 5 crc byte steps. mul
// adds a multiply and a fix step; div and rem add the radix-2 divider loop
// and a fix step. one transaction is in flight at a time; in_chan.ready rises
// in the same cycle as out_chan.valid. the result sits in an output register,
// so a stalled out_chan holds it while the next command is taken; that
// command's result waits until the held one is taken.
`timescale 1ns / 1ps
module rv32im_executor_with_crc_signature_unit #(
  parameter int MEM_BYTES = 65536
) (
  input logic      clk,
  input logic      rst_n,
  rvx_in_if.sink   in_chan,
  rvx_out_if.source out_chan
);
  import rvx_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rvx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rvx_datapath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_load_address     (in_chan.load_address),
    .in_load_word        (in_chan.load_word),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_status          (out_chan.status),
    .out_program_counter (out_chan.program_counter),
    .out_reg_written     (out_chan.reg_written),
    .out_reg_index       (out_chan.reg_index),
    .out_reg_value       (out_chan.reg_value),
    .out_signature       (out_chan.signature)
  );

endmodule
